// ----- sv/riodfr_pkg.sv -----
`default_nettype none
package riodfr_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W = 5;
	localparam int unsigned NUM_SAMPLES = 10;
	localparam int unsigned NUM_PACKED = 5;
	localparam int unsigned SAMPLE_IDX_W = 4;
	localparam int unsigned OUT_IDX_W = 3;

	localparam logic [POS_W-1:0] POS_START = 5'd0;
	localparam logic [POS_W-1:0] POS_FIRST_SUMMED = 5'd3;
	localparam logic [POS_W-1:0] POS_FIRST_SAMPLE = 5'd11;
	localparam logic [POS_W-1:0] POS_CHECK = 5'd21;
	localparam logic [POS_W-1:0] POS_IDLE = 5'd22;

	// result slots of one frame
	localparam logic [OUT_IDX_W-1:0] SLOT_TAG = 3'd0;
	localparam logic [OUT_IDX_W-1:0] SLOT_END = 3'd6;

	// configuration register indexes
	localparam logic [1:0] REG_START_DELIM = 2'd0;
	localparam logic [1:0] REG_FRAME_TAG = 2'd1;
	localparam logic [1:0] REG_END_MARKER = 2'd2;

	localparam logic [BYTE_W-1:0] RST_START_DELIM = 8'd126;
	localparam logic [BYTE_W-1:0] RST_FRAME_TAG = 8'd0;
	localparam logic [BYTE_W-1:0] RST_END_MARKER = 8'd4;

	typedef logic [NUM_PACKED-1:0][BYTE_W-1:0] frame_data_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// ----- sv/riodfr_front.sv -----
`default_nettype none
module riodfr_front
	import riodfr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic [BYTE_W-1:0] start_delimiter,
	output logic                   q_push,
	output frame_data_t            q_data
);

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] sample_q [NUM_SAMPLES];
	logic [POS_W-1:0]  pos_cur;
	logic [POS_W-1:0]  sample_off;
	logic              in_sum_range;
	logic              in_sample_range;

	always_comb begin
		pos_cur = (rx_byte == start_delimiter) ? POS_START : pos_q;
		in_sum_range = (pos_cur >= POS_FIRST_SUMMED) && (pos_cur < POS_CHECK);
		in_sample_range = (pos_cur >= POS_FIRST_SAMPLE) && (pos_cur < POS_CHECK);
		sample_off = pos_cur - POS_FIRST_SAMPLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_START;
			sum_q <= '0;
		end else if (accept) begin
			if (pos_cur == POS_START) begin
				sum_q <= '0;
			end else if (in_sum_range) begin
				sum_q <= sum_q + rx_byte;
			end
			if (pos_cur < POS_IDLE) begin
				pos_q <= pos_cur + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_sample_range) begin
			sample_q[sample_off[SAMPLE_IDX_W-1:0]] <= rx_byte;
		end
	end

	// checksum byte is 0xff minus the sum, i.e. its complement
	assign q_push = accept && (pos_cur == POS_CHECK) && (rx_byte == ~sum_q);

	always_comb begin
		for (int k = 0; k < NUM_PACKED; k++) begin
			q_data[k] = {sample_q[2*k][2:0], sample_q[2*k+1][7:3]};
		end
	end

endmodule
`default_nettype wire

// ----- sv/riodfr_queue.sv -----
`default_nettype none
module riodfr_queue
	import riodfr_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  frame_data_t push_data,
	input  wire logic  pop,
	output frame_data_t pop_data,
	output q_stat_t    stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	frame_data_t      entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full))
		else $error("frame pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty))
		else $error("frame popped from empty queue");

endmodule
`default_nettype wire

// ----- sv/riodfr_back.sv -----
`default_nettype none
module riodfr_back
	import riodfr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  q_stat_t                q_stat,
	input  frame_data_t            q_data,
	output logic                   q_pop,
	input  wire logic [BYTE_W-1:0] frame_tag,
	input  wire logic [BYTE_W-1:0] end_marker,
	input  wire logic              pop,
	output logic                   empty,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   last_of_frame
);

	logic                 active_q;
	logic [OUT_IDX_W-1:0] slot_q;
	frame_data_t          frame_q;
	logic                 taken;
	logic                 done;
	logic [OUT_IDX_W-1:0] packed_idx;

	assign empty = !active_q;
	assign taken = pop && active_q;
	assign done = taken && (slot_q == SLOT_END);
	assign q_pop = !q_stat.empty && (!active_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			slot_q <= SLOT_TAG;
		end else if (q_pop) begin
			active_q <= 1'b1;
			slot_q <= SLOT_TAG;
		end else if (done) begin
			active_q <= 1'b0;
			slot_q <= SLOT_TAG;
		end else if (taken) begin
			slot_q <= slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			frame_q <= q_data;
		end
	end

	assign packed_idx = slot_q - 3'd1;

	always_comb begin
		last_of_frame = 1'b0;
		case (slot_q)
			SLOT_TAG: out_byte = frame_tag;
			SLOT_END: begin
				out_byte = end_marker;
				last_of_frame = 1'b1;
			end
			default: out_byte = (packed_idx < OUT_IDX_W'(NUM_PACKED))
				? frame_q[packed_idx] : end_marker;
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/radio_io_frame_deframer.sv -----
// Radio I/O frame deframer. Takes one received byte per cycle unless full
// (push/full) and tracks the frame position: a byte equal to start_delimiter
// restarts at position 0, bytes 3..20 are summed, bytes 11..20 are kept, and
// at position 21 the byte is checked against 0xff minus that sum. A good
// frame yields seven results on the pop/empty side, one per cycle while pop
// is high: frame_tag, five packed sample bytes (low 3 bits of byte 11+2k
// above the top 5 bits of byte 12+2k), then end_marker with last_of_frame
// set. Checked frames wait in a queue of QUEUE_DEPTH entries, and full is
// high only while that queue holds QUEUE_DEPTH frames the output side has not
// started on. Registers sit on the APB port at 0x0 (start_delimiter), 0x4
// (frame_tag) and 0x8 (end_marker); write them only while the block is idle.
`default_nettype none
module radio_io_frame_deframer
	import riodfr_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        pop,
	output logic             empty,
	output logic [7:0]       out_byte,
	output logic             last_of_frame
);

	logic [BYTE_W-1:0] start_delim_q;
	logic [BYTE_W-1:0] frame_tag_q;
	logic [BYTE_W-1:0] end_marker_q;
	logic              cfg_wr;
	logic              in_accept;
	logic              q_push;
	logic              q_pop;
	frame_data_t       q_in_data;
	frame_data_t       q_out_data;
	q_stat_t           q_stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delim_q <= RST_START_DELIM;
			frame_tag_q <= RST_FRAME_TAG;
			end_marker_q <= RST_END_MARKER;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_START_DELIM: start_delim_q <= pwdata[7:0];
				REG_FRAME_TAG:   frame_tag_q <= pwdata[7:0];
				REG_END_MARKER:  end_marker_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_START_DELIM: prdata = {24'd0, start_delim_q};
			REG_FRAME_TAG:   prdata = {24'd0, frame_tag_q};
			REG_END_MARKER:  prdata = {24'd0, end_marker_q};
			default:         prdata = '0;
		endcase
	end

	assign full = q_stat.full;
	assign in_accept = push && !q_stat.full;

	riodfr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (in_accept),
		.rx_byte         (rx_byte),
		.start_delimiter (start_delim_q),
		.q_push          (q_push),
		.q_data          (q_in_data)
	);

	riodfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in_data),
		.pop       (q_pop),
		.pop_data  (q_out_data),
		.stat      (q_stat)
	);

	riodfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.q_data        (q_out_data),
		.q_pop         (q_pop),
		.frame_tag     (frame_tag_q),
		.end_marker    (end_marker_q),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.last_of_frame (last_of_frame)
	);

endmodule
`default_nettype wire

// ----- tb/sv/tb_radio_io_frame_deframer.sv -----
`timescale 1ns / 100ps
module tb_radio_io_frame_deframer;
	import riodfr_pkg::*;

	localparam logic [3:0] ADDR_UNUSED = 4'hc;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 250;

	typedef struct packed {
		logic [7:0] ob;
		logic       lof;
	} out_t;

	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		logic [2:0] n_out;
	} dir_row_t;

	typedef enum {
		FK_GOOD,
		FK_BAD_SUM,
		FK_DELIM_AT_CHECK,
		FK_OVERLONG,
		FK_TRUNC,
		FK_NOISE
	} frame_kind_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic        pop;
	logic        empty;
	logic [7:0]  out_byte;
	logic        last_of_frame;

	// deframer copy: configuration and frame state
	logic [7:0] cfg_delim;
	logic [7:0] cfg_tag;
	logic [7:0] cfg_eom;
	logic [4:0] fpos;
	logic [7:0] fsamp [0:9];
	logic [7:0] fsum;
	out_t       pred_out [0:6];

	out_t out_due [$];
	out_t seen_want;
	int   fails;
	int   items_in;
	int   snd_idle;
	int   rcv_idle;
	logic hold_go;
	logic hold_taken;
	int   hold_left;
	int   dir_pos;

	// frame with no delimiter after reset, all-zero bytes 3..10 and all-ones samples, then overrun
	dir_row_t dir_tab [0:25] = '{
		{8'h00, 1'b1, 3'd0}, {8'hff, 1'b1, 3'd0}, {8'h55, 1'b1, 3'd0},
		{8'h00, 1'b1, 3'd0}, {8'h00, 1'b1, 3'd0}, {8'h00, 1'b1, 3'd0},
		{8'h00, 1'b1, 3'd0}, {8'h00, 1'b1, 3'd0}, {8'h00, 1'b1, 3'd0},
		{8'h00, 1'b1, 3'd0}, {8'h00, 1'b1, 3'd0},
		{8'hff, 1'b1, 3'd0}, {8'hff, 1'b1, 3'd0}, {8'hff, 1'b1, 3'd0},
		{8'hff, 1'b1, 3'd0}, {8'hff, 1'b1, 3'd0}, {8'hff, 1'b1, 3'd0},
		{8'hff, 1'b1, 3'd0}, {8'hff, 1'b1, 3'd0}, {8'hff, 1'b1, 3'd0},
		{8'hff, 1'b1, 3'd0},
		{8'h09, 1'b1, 3'd7},
		{8'hff, 1'b1, 3'd0}, {8'h80, 1'b1, 3'd0},
		{8'h7e, 1'b0, 3'd0}, {8'h01, 1'b0, 3'd0}
	};

	out_t dir_want [0:6] = '{
		{RST_FRAME_TAG, 1'b0}, {8'hff, 1'b0}, {8'hff, 1'b0}, {8'hff, 1'b0},
		{8'hff, 1'b0}, {8'hff, 1'b0}, {RST_END_MARKER, 1'b1}
	};

	radio_io_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.pop(pop),
		.empty(empty),
		.out_byte(out_byte),
		.last_of_frame(last_of_frame)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic void deframe_reset();
		cfg_delim = RST_START_DELIM;
		cfg_tag = RST_FRAME_TAG;
		cfg_eom = RST_END_MARKER;
		fpos = POS_START;
		fsum = 8'h00;
		for (int i = 0; i < 10; i++)
			fsamp[i] = 8'h00;
	endfunction

	// returns how many output bytes the byte releases, left in pred_out
	function automatic int deframe_byte(input logic [7:0] b);
		logic [4:0] p;
		int n;
		n = 0;
		if (b == cfg_delim)
			fpos = POS_START;
		p = fpos;
		if (p == POS_START)
			fsum = 8'h00;
		else if (p >= POS_FIRST_SUMMED && p < POS_CHECK)
			fsum = fsum + b;
		if (p >= POS_FIRST_SAMPLE && p < POS_CHECK)
			fsamp[p - POS_FIRST_SAMPLE] = b;
		if (p == POS_CHECK && b == 8'(8'hff - fsum)) begin
			pred_out[0] = {cfg_tag, 1'b0};
			for (int k = 0; k < 5; k++)
				pred_out[k + 1] = {fsamp[2 * k][2:0], fsamp[2 * k + 1][7:3], 1'b0};
			pred_out[6] = {cfg_eom, 1'b1};
			n = 7;
		end
		if (p < POS_IDLE)
			fpos = p + 5'd1;
		return n;
	endfunction

	function automatic logic [7:0] pick_byte();
		logic [7:0] v;
		do
			v = 8'($urandom_range(255));
		while (v == cfg_delim);
		return v;
	endfunction

	// typed_n < 0: expected bytes come from the deframer copy
	task automatic offer_byte(input logic [7:0] b, input int typed_n);
		int n;
		while ($urandom_range(99) < snd_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (full);
		n = deframe_byte(b);
		if (typed_n < 0) begin
			for (int i = 0; i < n; i++)
				out_due.push_back(pred_out[i]);
		end else begin
			for (int i = 0; i < typed_n; i++) begin
				out_due.push_back(dir_want[dir_pos]);
				dir_pos++;
			end
		end
		items_in++;
	endtask

	task automatic send_frame(input frame_kind_t kind);
		logic [7:0] fb [0:21];
		logic [7:0] s;
		int extra;
		if (kind == FK_NOISE) begin
			extra = $urandom_range(8, 1);
			repeat (extra) offer_byte(8'($urandom_range(255)), -1);
		end else if (kind == FK_TRUNC) begin
			offer_byte(cfg_delim, -1);
			extra = $urandom_range(20, 1);
			repeat (extra) offer_byte(pick_byte(), -1);
		end else begin
			do begin
				fb[0] = cfg_delim;
				for (int i = 1; i < 21; i++)
					fb[i] = pick_byte();
				s = 8'h00;
				for (int i = 3; i < 21; i++)
					s = s + fb[i];
				fb[21] = 8'hff - s;
			end while (fb[21] == cfg_delim && kind != FK_DELIM_AT_CHECK);
			if (kind == FK_BAD_SUM) begin
				fb[21] = fb[21] ^ 8'(1 << $urandom_range(7));
			end else if (kind == FK_DELIM_AT_CHECK) begin
				// make the delimiter the matching check byte too
				fb[3] = fb[3] + fb[21] - cfg_delim;
				fb[21] = cfg_delim;
			end
			for (int i = 0; i < 22; i++)
				offer_byte(fb[i], -1);
			if (kind == FK_OVERLONG) begin
				extra = $urandom_range(4, 1);
				repeat (extra) offer_byte(pick_byte(), -1);
			end
		end
	endtask

	task automatic wait_drained();
		while (out_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_items(input int n_items, input int n_good_first);
		int stop_at;
		int r;
		frame_kind_t k;
		stop_at = items_in + n_items;
		while (items_in < stop_at) begin
			r = $urandom_range(99);
			if (n_good_first > 0) begin
				k = FK_GOOD;
				n_good_first--;
			end else if (r < 58) begin
				k = FK_GOOD;
			end else if (r < 68) begin
				k = FK_BAD_SUM;
			end else if (r < 76) begin
				k = FK_DELIM_AT_CHECK;
			end else if (r < 86) begin
				k = FK_OVERLONG;
			end else if (r < 94) begin
				k = FK_TRUNC;
			end else begin
				k = FK_NOISE;
			end
			send_frame(k);
		end
		push <= 1'b0;
		wait_drained();
	endtask

	task automatic apb_write(input logic [3:0] a, input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= {24'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (a[3:2])
			REG_START_DELIM: cfg_delim = v;
			REG_FRAME_TAG: cfg_tag = v;
			REG_END_MARKER: cfg_eom = v;
			default: ;
		endcase
	endtask

	task automatic apb_check(input logic [3:0] a, input logic [7:0] v);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== {24'h0, v}) begin
			$display("%0t: register at %h expected %h got %h", $time, a, {24'h0, v}, got);
			fails++;
		end
	endtask

	task automatic set_regs(input logic [7:0] d, input logic [7:0] t, input logic [7:0] e);
		apb_write({REG_START_DELIM, 2'b00}, d);
		apb_write({REG_FRAME_TAG, 2'b00}, t);
		apb_write({REG_END_MARKER, 2'b00}, e);
		apb_check({REG_START_DELIM, 2'b00}, cfg_delim);
		apb_check({REG_FRAME_TAG, 2'b00}, cfg_tag);
		apb_check({REG_END_MARKER, 2'b00}, cfg_eom);
	endtask

	// output side: random pop, one long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_left != 0) begin
			pop <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_taken) begin
			pop <= 1'b0;
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else begin
			pop <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (out_due.size() == 0) begin
				$display("%0t: unexpected output: expected none, got out_byte %h last_of_frame %b",
					$time, out_byte, last_of_frame);
				fails++;
			end else begin
				seen_want = out_due.pop_front();
				if (out_byte !== seen_want.ob) begin
					$display("%0t: out_byte expected %h got %h", $time, seen_want.ob, out_byte);
					fails++;
				end
				if (last_of_frame !== seen_want.lof) begin
					$display("%0t: last_of_frame expected %b got %b", $time, seen_want.lof,
						last_of_frame);
					fails++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 4'h0;
		pwdata <= 32'h0;
		push <= 1'b0;
		rx_byte <= 8'h00;
		hold_go <= 1'b0;
		rcv_idle <= 51;
		snd_idle = 19;
		fails = 0;
		items_in = 0;
		dir_pos = 0;
		deframe_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_check({REG_START_DELIM, 2'b00}, RST_START_DELIM);
		apb_check({REG_FRAME_TAG, 2'b00}, RST_FRAME_TAG);
		apb_check({REG_END_MARKER, 2'b00}, RST_END_MARKER);

		foreach (dir_tab[i])
			offer_byte(dir_tab[i].rx, dir_tab[i].typed ? int'(dir_tab[i].n_out) : -1);
		random_items(80, 0);

		set_regs(8'h00, 8'hff, 8'hff);
		// write to the unmapped slot must change nothing
		apb_write(ADDR_UNUSED, 8'ha5);
		apb_check({REG_START_DELIM, 2'b00}, cfg_delim);
		random_items(85, 0);

		snd_idle = 51;
		rcv_idle <= 19;
		set_regs(8'hff, 8'h00, 8'h00);
		random_items(90, 0);

		snd_idle = 0;
		rcv_idle <= 0;
		set_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		// output side stalls while good frames keep coming, so the input backs up
		hold_go <= 1'b1;
		random_items(90, 6);

		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
